// File: hdl/pthc_pkg.sv
// ----------------------------------------------------------------------------
// Poker-test hand classifier package
// Shared widths, class codes and the control bundle passed to the counter bank.
// ----------------------------------------------------------------------------
package pthc_pkg;

  localparam int COUNT_WIDTH = 16;   // counter width, 8 to 32
  localparam int DIGIT_WIDTH = 4;
  localparam int HAND_SIZE   = 4;
  localparam int CLASS_COUNT = 5;
  localparam int FIELD_WIDTH = 16;   // reported width of each count
  localparam int CLASS_WIDTH = 3;

  localparam int IN_DATA_WIDTH  = DIGIT_WIDTH * HAND_SIZE;
  localparam int OUT_USED_WIDTH = CLASS_WIDTH + CLASS_COUNT * FIELD_WIDTH;
  localparam int OUT_DATA_WIDTH = ((OUT_USED_WIDTH + 7) / 8) * 8;
  localparam int OUT_PAD_WIDTH  = OUT_DATA_WIDTH - OUT_USED_WIDTH;

  typedef logic [DIGIT_WIDTH-1:0] digit_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [FIELD_WIDTH-1:0] field_t;

  typedef enum logic [CLASS_WIDTH-1:0] {
    CLASS_ALL_SAME      = 3'd0,
    CLASS_THREE_SAME    = 3'd1,
    CLASS_TWO_PAIRS     = 3'd2,
    CLASS_ONE_PAIR      = 3'd3,
    CLASS_ALL_DIFFERENT = 3'd4
  } hand_class_t;

  // One counted hand: strobe, its class, and whether it closes the run.
  typedef struct packed {
    logic        valid;
    logic        last;
    hand_class_t cls;
  } count_ctl_t;

  // Low FIELD_WIDTH bits of a counter, zero-extended when the counter is narrower.
  function automatic field_t to_field(input count_t c);
    logic [31:0] ext;
    ext = 32'(c);
    return ext[FIELD_WIDTH-1:0];
  endfunction

endpackage

// File: hdl/pthc_classify.sv
// ----------------------------------------------------------------------------
// Hand classifier
// Sorts four digits with a five-exchange network and names the hand's class.
// ----------------------------------------------------------------------------
module pthc_classify (
  input  pthc_pkg::digit_t      digits [pthc_pkg::HAND_SIZE],
  output pthc_pkg::hand_class_t cls
);

  pthc_pkg::digit_t s0 [pthc_pkg::HAND_SIZE];
  pthc_pkg::digit_t s1 [pthc_pkg::HAND_SIZE];
  pthc_pkg::digit_t s2 [pthc_pkg::HAND_SIZE];
  logic e01, e12, e23;

  // Layer 1: (0,1) (2,3); layer 2: (0,2) (1,3); layer 3: (1,2).
  always_comb begin
    s0[0] = (digits[0] > digits[1]) ? digits[1] : digits[0];
    s0[1] = (digits[0] > digits[1]) ? digits[0] : digits[1];
    s0[2] = (digits[2] > digits[3]) ? digits[3] : digits[2];
    s0[3] = (digits[2] > digits[3]) ? digits[2] : digits[3];

    s1[0] = (s0[0] > s0[2]) ? s0[2] : s0[0];
    s1[2] = (s0[0] > s0[2]) ? s0[0] : s0[2];
    s1[1] = (s0[1] > s0[3]) ? s0[3] : s0[1];
    s1[3] = (s0[1] > s0[3]) ? s0[1] : s0[3];

    s2[0] = s1[0];
    s2[3] = s1[3];
    s2[1] = (s1[1] > s1[2]) ? s1[2] : s1[1];
    s2[2] = (s1[1] > s1[2]) ? s1[1] : s1[2];
  end

  assign e01 = (s2[0] == s2[1]);
  assign e12 = (s2[1] == s2[2]);
  assign e23 = (s2[2] == s2[3]);

  always_comb begin
    priority if (e01 && e12 && e23) begin
      cls = pthc_pkg::CLASS_ALL_SAME;
    end else if ((e01 && e12) || (e12 && e23)) begin
      cls = pthc_pkg::CLASS_THREE_SAME;
    end else if (e01 && e23) begin
      cls = pthc_pkg::CLASS_TWO_PAIRS;
    end else if (e01 || e12 || e23) begin
      cls = pthc_pkg::CLASS_ONE_PAIR;
    end else begin
      cls = pthc_pkg::CLASS_ALL_DIFFERENT;
    end
  end

endmodule

// File: hdl/pthc_counters.sv
// ----------------------------------------------------------------------------
// Class counter bank
// Saturating per-class counters; reports post-increment counts, clears on last.
// ----------------------------------------------------------------------------
module pthc_counters (
  input  logic                 clk,
  input  logic                 rst,
  input  pthc_pkg::count_ctl_t ctl,
  output pthc_pkg::field_t     report [pthc_pkg::CLASS_COUNT]
);

  pthc_pkg::count_t cnt      [pthc_pkg::CLASS_COUNT];
  pthc_pkg::count_t cnt_next [pthc_pkg::CLASS_COUNT];

  always_comb begin
    for (int i = 0; i < pthc_pkg::CLASS_COUNT; i++) begin
      cnt_next[i] = cnt[i];
      if (ctl.cls == pthc_pkg::hand_class_t'(i) && cnt[i] != '1) begin
        cnt_next[i] = cnt[i] + pthc_pkg::count_t'(1);
      end
      report[i] = pthc_pkg::to_field(cnt_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pthc_pkg::CLASS_COUNT; i++) begin
        cnt[i] <= '0;
      end
    end else if (ctl.valid) begin
      for (int i = 0; i < pthc_pkg::CLASS_COUNT; i++) begin
        cnt[i] <= ctl.last ? '0 : cnt_next[i];
      end
    end
  end

endmodule

// File: hdl/poker_test_hand_classifier_unit.sv
// ----------------------------------------------------------------------------
// Poker-test hand classifier unit
// Classifies four-digit hands and keeps saturating per-class running counts.
// ----------------------------------------------------------------------------
// Stages: input register, then result register.
// Throughput: one hand per cycle while m_axis_tready is high; the stages advance
//   together; while a result stalls, a new beat enters only an empty input register.
// Reset: rst (synchronous, active high) empties both stages and clears all counters.
// ----------------------------------------------------------------------------
module poker_test_hand_classifier_unit (
  input  logic clk,
  input  logic rst,

  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // digit_a [3:0], digit_b [7:4], digit_c [11:8], digit_d [15:12]
  input  logic [pthc_pkg::IN_DATA_WIDTH-1:0]   s_axis_tdata,
  input  logic                                 s_axis_tlast,   // last_hand

  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // hand_class [2:0], count_all_same [18:3], count_three_same [34:19],
  // count_two_pairs [50:35], count_one_pair [66:51], count_all_different [82:67],
  // zero pad [87:83]
  output logic [pthc_pkg::OUT_DATA_WIDTH-1:0]  m_axis_tdata,
  output logic                                 m_axis_tlast    // run_done
);

  // Input register stage.
  logic                                 in_valid;
  logic [pthc_pkg::IN_DATA_WIDTH-1:0]   in_data;
  logic                                 in_last;

  // Result register stage.
  logic                                 res_valid;
  logic [pthc_pkg::OUT_DATA_WIDTH-1:0]  res_data;
  logic                                 res_last;

  logic                  res_load;     // input stage moves into the result stage
  logic                  in_free;      // input stage can take a beat
  pthc_pkg::digit_t      digits [pthc_pkg::HAND_SIZE];
  pthc_pkg::hand_class_t cls;
  pthc_pkg::count_ctl_t  ctl;
  pthc_pkg::field_t      report [pthc_pkg::CLASS_COUNT];

  // Load the result stage when the input stage holds a beat and the result stage is empty or draining.
  assign res_load      = in_valid && (!res_valid || m_axis_tready);
  assign in_free       = !in_valid || res_load;
  assign s_axis_tready = in_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_free) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // Payload: hold unless a new beat is taken.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && in_free) begin
      in_data <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_comb begin
    for (int i = 0; i < pthc_pkg::HAND_SIZE; i++) begin
      digits[i] = in_data[i*pthc_pkg::DIGIT_WIDTH +: pthc_pkg::DIGIT_WIDTH];
    end
  end

  pthc_classify u_classify (
    .digits (digits),
    .cls    (cls)
  );

  // Count a hand exactly once, on the cycle it moves into the result stage.
  assign ctl.valid = res_load;
  assign ctl.last  = in_last;
  assign ctl.cls   = cls;

  pthc_counters u_counters (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .report (report)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data <= {pthc_pkg::OUT_PAD_WIDTH'(0), report[4], report[3], report[2],
                   report[1], report[0], cls};
      res_last <= in_last;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = res_data;
  assign m_axis_tlast  = res_last;

endmodule
